### hdl/qphs_pkg.sv
// Shared types, constants and codes for the quadratic probing hash set.
package qphs_pkg;

  localparam int SLOTS       = 1024;
  localparam int KEY_BITS    = 31;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int CFG_W       = 11;
  localparam int DIV_W       = $clog2(KEY_BITS);
  localparam int PRIME_RESET = 5;
  localparam int STAT_W      = 2;
  localparam int REQ_W       = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISS  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [KEY_BITS-1:0] key;
  } qphs_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  entry_count;
  } qphs_out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_INIT,
    S_PROBE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic div_step;
    logic init;
    logic probe;
    logic finish;
  } qphs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic probe_end;
    logic out_full;
  } qphs_sts_t;

endpackage

### hdl/qphs_ctrl.sv
// Sequencing state machine for the quadratic probing hash set.
module qphs_ctrl
  import qphs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  qphs_sts_t sts,
  output qphs_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid)     state_nxt = S_DIV;
      S_DIV:   if (sts.div_last) state_nxt = S_INIT;
      S_INIT:                    state_nxt = S_PROBE;
      S_PROBE: if (sts.probe_end) state_nxt = S_DONE;
      S_DONE:  if (!sts.out_full) state_nxt = S_IDLE;
      default:                   state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clr = 1'b1;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_INIT:  cmd.init = 1'b1;
      S_PROBE: cmd.probe = 1'b1;
      S_DONE:  cmd.finish = !sts.out_full;
      default: cmd = '0;
    endcase
  end

endmodule

### hdl/qphs_dp.sv
// Datapath: slot store, home slot divider, probe sequence and result registers.
module qphs_dp
  import qphs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  qphs_in_t         in_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             out_ready,
  output logic             out_valid,
  output qphs_out_t        out_data,
  input  qphs_cmd_t        cmd,
  output qphs_sts_t        sts
);

  // Slot store: {valid, key} per entry
  logic [KEY_BITS:0] mem [SLOTS];
  logic [KEY_BITS:0] mem_q_r;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [KEY_BITS:0] wr_data;

  logic [CFG_W-1:0]    cfg_prime_r;
  logic [CNT_W-1:0]    n_clamp;
  logic [CNT_W-1:0]    n_r;
  logic [SLOT_W-1:0]   lim_r;
  logic [REQ_W-1:0]    req_r;
  logic [KEY_BITS-1:0] key_r;

  logic [SLOT_W-1:0] clr_addr_r;

  logic [KEY_BITS-1:0] key_sh_r;
  logic [SLOT_W-1:0]   rem_r;
  logic [SLOT_W-1:0]   rem_nxt;
  logic [DIV_W-1:0]    div_cnt_r;
  logic [SLOT_W:0]     div_t;

  logic [SLOT_W-1:0] s_r;
  logic [SLOT_W-1:0] d_r;
  logic [SLOT_W-1:0] s_nxt;
  logic [SLOT_W-1:0] d_nxt;
  logic [CNT_W-1:0]  s_sum;
  logic [CNT_W-1:0]  d_sum;
  logic [SLOT_W-1:0] iss_p_r;
  logic              iss_on_r;

  logic              cmp_vld_r;
  logic [SLOT_W-1:0] cmp_slot_r;
  logic              cmp_last_r;

  logic q_valid;
  logic q_match;
  logic cmp_hit;
  logic probe_end;

  logic [STAT_W-1:0] res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              out_valid_r;
  qphs_out_t         out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_prime_r <= CFG_W'(PRIME_RESET);
    end else if (cfg_we) begin
      cfg_prime_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (cfg_prime_r < CFG_W'(2)) begin
      n_clamp = CNT_W'(2);
    end else if (cfg_prime_r > CFG_W'(SLOTS)) begin
      n_clamp = CNT_W'(SLOTS);
    end else begin
      n_clamp = CNT_W'(cfg_prime_r);
    end
  end

  // Restoring division, one key bit a cycle, remainder only
  assign div_t   = {rem_r, key_sh_r[KEY_BITS-1]};
  assign rem_nxt = (div_t >= n_r) ? SLOT_W'(div_t - n_r) : SLOT_W'(div_t);

  // Next probe: s += 2p+1 and d += 2, both kept below n
  assign s_sum = {1'b0, s_r} + {1'b0, d_r};
  assign s_nxt = (s_sum >= n_r) ? SLOT_W'(s_sum - n_r) : SLOT_W'(s_sum);
  assign d_sum = {1'b0, d_r} + CNT_W'(2);
  assign d_nxt = (d_sum >= n_r) ? SLOT_W'(d_sum - n_r) : SLOT_W'(d_sum);

  assign q_valid = mem_q_r[KEY_BITS];
  assign q_match = q_valid && (mem_q_r[KEY_BITS-1:0] == key_r);

  always_comb begin
    cmp_hit = 1'b0;
    if (cmp_vld_r) begin
      if (req_r == REQ_INSERT) begin
        cmp_hit = q_match || !q_valid;
      end else if (req_r == REQ_REMOVE || req_r == REQ_SEARCH) begin
        cmp_hit = q_match;
      end
    end
  end

  // An unused request code ends at once as a miss
  assign probe_end = cmd.probe &&
                     (cmp_hit || (cmp_vld_r && cmp_last_r) ||
                      !(req_r == REQ_INSERT || req_r == REQ_REMOVE || req_r == REQ_SEARCH));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r       <= n_clamp;
      lim_r     <= SLOT_W'(n_clamp >> 1) + SLOT_W'(1);
      req_r     <= in_data.req_type;
      key_r     <= in_data.key;
      key_sh_r  <= in_data.key;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      key_sh_r  <= {key_sh_r[KEY_BITS-2:0], 1'b0};
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DIV_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_on_r  <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else if (cmd.init) begin
      iss_on_r  <= 1'b1;
      cmp_vld_r <= 1'b0;
    end else if (cmd.probe) begin
      cmp_vld_r <= iss_on_r;
      if (iss_on_r && iss_p_r == lim_r) begin
        iss_on_r <= 1'b0;
      end
    end else begin
      iss_on_r  <= 1'b0;
      cmp_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      s_r     <= rem_r;
      d_r     <= SLOT_W'(1);
      iss_p_r <= '0;
    end else if (cmd.probe && iss_on_r) begin
      s_r        <= s_nxt;
      d_r        <= d_nxt;
      iss_p_r    <= iss_p_r + SLOT_W'(1);
      cmp_slot_r <= s_r;
      cmp_last_r <= (iss_p_r == lim_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr) begin
      clr_addr_r <= clr_addr_r + SLOT_W'(1);
    end
  end

  always_comb begin
    rd_addr = s_r;
    wr_en   = 1'b0;
    wr_addr = cmp_slot_r;
    wr_data = {1'b1, key_r};
    if (cmd.clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (probe_end && cmp_hit) begin
      if (req_r == REQ_INSERT && !q_valid) begin
        wr_en = 1'b1;
      end else if (req_r == REQ_REMOVE) begin
        wr_en   = 1'b1;
        wr_data = {1'b0, key_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (probe_end && cmp_hit) begin
      if (req_r == REQ_INSERT && !q_valid) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (req_r == REQ_REMOVE && cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (probe_end) begin
      if (cmp_hit) begin
        res_status_r <= (req_r == REQ_INSERT && q_valid) ? STAT_DUP : STAT_OK;
        res_slot_r   <= cmp_slot_r;
      end else begin
        res_status_r <= (req_r == REQ_INSERT) ? STAT_LIMIT : STAT_MISS;
        res_slot_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.status      <= res_status_r;
      out_data_r.slot_index  <= res_slot_r;
      out_data_r.entry_count <= cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.clr_last  = (clr_addr_r == SLOT_W'(SLOTS - 1));
  assign sts.div_last  = (div_cnt_r == DIV_W'(KEY_BITS - 1));
  assign sts.probe_end = probe_end;
  assign sts.out_full  = out_valid_r && !out_ready;

endmodule

### hdl/quadratic_probe_hash_set.sv
// Hash set with quadratic probing over a prime-sized slot table: top level.
// After reset the block sweeps the slot store to mark every slot empty, and no
// item is taken meanwhile. An item then finds its home slot in a divider that
// shifts and subtracts, one key bit a cycle, sets up the probe, and probes
// the slots in turn through the single read port of the slot store, whose read
// data are registered; a scan stops early at the first slot that settles the
// request. The result is then loaded into the output register.
// A request code of 3 finishes after the divider with a miss. The result sits
// in an output register, so the next item may be taken while it waits.
module quadratic_probe_hash_set
  import qphs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  qphs_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output qphs_out_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  qphs_cmd_t cmd;
  qphs_sts_t sts;

  qphs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qphs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### hdl/qphs_chk.sv
// Port-level checker for the quadratic probing hash set, bound to the top level.
module qphs_chk
  import qphs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input qphs_out_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Misses and probe-limit results carry slot zero
  a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_MISS || out_data.status == STAT_LIMIT)
      |-> out_data.slot_index == '0)
    else $error("non-zero slot on miss");

  // One item at a time: drop ready after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // Entry count never exceeds the slot store
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= CNT_W'(SLOTS))
    else $error("entry count out of range");

endmodule

bind quadratic_probe_hash_set qphs_chk u_qphs_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### verif/tb_top.sv
// Testbench for the quadratic probing hash set: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
  import qphs_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT = 3_000_000;
  localparam logic [KEY_BITS-1:0] KEY_TOP = '1;

  typedef struct {
    qphs_in_t  rq;
    bit        typed;
    qphs_out_t res;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  qphs_in_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  qphs_out_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Shadow copy of the slot store and the size register
  logic                occupied [SLOTS];
  logic [KEY_BITS-1:0] stored_key [SLOTS];
  int unsigned         key_total;
  logic [CFG_W-1:0]    prime_reg;

  qphs_out_t   pending [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;
  plan_row_t   plan [20];

  quadratic_probe_hash_set dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int unsigned used_size(input logic [CFG_W-1:0] v);
    int unsigned n;
    n = 32'(v);
    if (n < 2) n = 2;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  // Apply one request to the shadow store and return the result it gives
  function automatic qphs_out_t hash_apply(input qphs_in_t rq);
    int unsigned n, bound, home, s, p;
    bit          done;
    qphs_out_t   r;
    n = used_size(prime_reg);
    bound = n / 2 + 1;
    home = rq.key % n;
    done = 1'b0;
    r.status = (rq.req_type == REQ_INSERT) ? STAT_LIMIT : STAT_MISS;
    r.slot_index = '0;
    if (rq.req_type != REQ_UNUSED) begin
      for (p = 0; p <= bound && !done; p++) begin
        s = (home + p * p) % n;
        if (occupied[s] && stored_key[s] == rq.key) begin
          done = 1'b1;
          r.slot_index = s[SLOT_W-1:0];
          if (rq.req_type == REQ_INSERT) begin
            r.status = STAT_DUP;
          end else begin
            r.status = STAT_OK;
            if (rq.req_type == REQ_REMOVE) begin
              occupied[s] = 1'b0;
              if (key_total > 0) key_total--;
            end
          end
        end else if (!occupied[s] && rq.req_type == REQ_INSERT) begin
          // First empty slot takes the key; copies further along stay unseen
          done = 1'b1;
          occupied[s] = 1'b1;
          stored_key[s] = rq.key;
          key_total++;
          r.status = STAT_OK;
          r.slot_index = s[SLOT_W-1:0];
        end
      end
    end
    r.entry_count = key_total[CNT_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t mk_row(input logic [REQ_W-1:0] req,
                                       input logic [KEY_BITS-1:0] key, input bit typed,
                                       input logic [STAT_W-1:0] st, input int unsigned slot,
                                       input int unsigned cnt);
    plan_row_t row;
    row.rq.req_type = req;
    row.rq.key = key;
    row.typed = typed;
    row.res.status = st;
    row.res.slot_index = slot[SLOT_W-1:0];
    row.res.entry_count = cnt[CNT_W-1:0];
    return row;
  endfunction

  // Offer one item after a random gap, hold it until taken, then queue its expected result
  task automatic drive(input qphs_in_t rq, input bit typed, input qphs_out_t typed_res);
    int unsigned gap, roll;
    qphs_out_t   predicted;
    gap = 0;
    if (!quiet) begin
      roll = $urandom_range(0, 99);
      if (roll >= 92) gap = $urandom_range(10, 60);
      else if (roll >= 55) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    do @(posedge clk); while (!in_ready);
    predicted = hash_apply(rq);
    pending.push_back(typed ? typed_res : predicted);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cfg_val, input bit do_write,
                           input int unsigned items, input bit calm);
    logic [KEY_BITS-1:0] pool [$];
    logic [KEY_BITS-1:0] kv;
    int unsigned         n, pool_len, roll, i;
    qphs_in_t            rq;
    qphs_out_t           nores;
    // Drain before touching the size register
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (do_write) begin
      cfg_we <= 1'b1;
      cfg_wdata <= cfg_val;
      @(posedge clk);
      cfg_we <= 1'b0;
      prime_reg = cfg_val;
    end
    quiet = calm;
    nores = '0;
    n = used_size(prime_reg);
    pool_len = $urandom_range(3, (n > 16) ? 40 : 2 * n + 4);
    for (i = 0; i < pool_len; i++) begin
      case ($urandom_range(0, 3))
        0: kv = KEY_BITS'($urandom);
        1: kv = KEY_BITS'($urandom_range(0, 63));
        2: kv = KEY_BITS'($urandom_range(0, 7) * n + $urandom_range(0, 2));
        default: kv = KEY_TOP - KEY_BITS'($urandom_range(0, 3 * n));
      endcase
      pool.push_back(kv);
    end
    for (i = 0; i < items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) rq.req_type = REQ_INSERT;
      else if (roll < 65) rq.req_type = REQ_REMOVE;
      else if (roll < 95) rq.req_type = REQ_SEARCH;
      else rq.req_type = REQ_UNUSED;
      // Mostly keys from the pool so that hits and collisions happen; some noise
      if ($urandom_range(0, 99) < 85) rq.key = pool[$urandom_range(0, pool.size() - 1)];
      else rq.key = KEY_BITS'($urandom);
      drive(rq, 1'b0, nores);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin : ready_gen
    int unsigned roll;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        out_ready <= 1'b1;
      end else if (roll < 92) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk) begin : result_check
    qphs_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d slot %0d count %0d",
                   out_data.status, out_data.slot_index, out_data.entry_count);
      end else begin
        want = pending.pop_front();
        if (out_data.status !== want.status || out_data.slot_index !== want.slot_index ||
            out_data.entry_count !== want.entry_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d slot %0d count %0d, got %0d %0d %0d",
                     want.status, want.slot_index, want.entry_count,
                     out_data.status, out_data.slot_index, out_data.entry_count);
        end
      end
    end
  end

  initial begin
    foreach (occupied[i]) begin
      occupied[i] = 1'b0;
      stored_key[i] = '0;
    end
    key_total = 0;
    prime_reg = CFG_W'(PRIME_RESET);

    // Size 5 after reset; typed rows are read straight off the probe sequence
    plan[0]  = mk_row(REQ_SEARCH, '0, 1'b1, STAT_MISS, 0, 0);
    plan[1]  = mk_row(REQ_REMOVE, '0, 1'b1, STAT_MISS, 0, 0);
    plan[2]  = mk_row(REQ_INSERT, '0, 1'b1, STAT_OK, 0, 1);
    plan[3]  = mk_row(REQ_INSERT, '0, 1'b1, STAT_DUP, 0, 1);
    plan[4]  = mk_row(REQ_INSERT, KEY_TOP, 1'b1, STAT_OK, 2, 2);
    plan[5]  = mk_row(REQ_SEARCH, KEY_TOP, 1'b0, STAT_OK, 0, 0);
    plan[6]  = mk_row(REQ_INSERT, 31'd5, 1'b0, STAT_OK, 0, 0);
    plan[7]  = mk_row(REQ_INSERT, 31'd10, 1'b0, STAT_OK, 0, 0);
    plan[8]  = mk_row(REQ_INSERT, 31'd15, 1'b1, STAT_LIMIT, 0, 4);
    plan[9]  = mk_row(REQ_UNUSED, 31'd5, 1'b1, STAT_MISS, 0, 4);
    plan[10] = mk_row(REQ_REMOVE, 31'd5, 1'b0, STAT_OK, 0, 0);
    // Re-insert into the freed slot while the old copy still sits further on
    plan[11] = mk_row(REQ_INSERT, 31'd10, 1'b0, STAT_OK, 0, 0);
    plan[12] = mk_row(REQ_SEARCH, 31'd10, 1'b0, STAT_OK, 0, 0);
    plan[13] = mk_row(REQ_REMOVE, 31'd10, 1'b0, STAT_OK, 0, 0);
    plan[14] = mk_row(REQ_SEARCH, 31'd10, 1'b0, STAT_OK, 0, 0);
    plan[15] = mk_row(REQ_REMOVE, 31'd10, 1'b0, STAT_OK, 0, 0);
    plan[16] = mk_row(REQ_SEARCH, 31'd10, 1'b0, STAT_OK, 0, 0);
    plan[17] = mk_row(REQ_INSERT, 31'd3, 1'b0, STAT_OK, 0, 0);
    plan[18] = mk_row(REQ_REMOVE, KEY_TOP, 1'b0, STAT_OK, 0, 0);
    plan[19] = mk_row(REQ_SEARCH, 31'h5555_5555, 1'b0, STAT_OK, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) drive(plan[i].rq, plan[i].typed, plan[i].res);
    in_valid <= 1'b0;

    run_phase(11'd5, 1'b0, 150, 1'b0);
    run_phase(11'd2, 1'b1, 100, 1'b0);
    run_phase(11'd0, 1'b1, 40, 1'b0);
    run_phase(11'd3, 1'b1, 100, 1'b0);
    run_phase(11'd7, 1'b1, 120, 1'b0);
    run_phase(11'd11, 1'b1, 120, 1'b1);
    run_phase(11'd8, 1'b1, 80, 1'b0);
    run_phase(11'd13, 1'b1, 100, 1'b0);
    run_phase(11'd1021, 1'b1, 25, 1'b0);
    run_phase(11'd2047, 1'b1, 15, 1'b0);
    // Shrink with keys left beyond the new size
    run_phase(11'd1, 1'b1, 40, 1'b0);
    run_phase(11'd31, 1'b1, 100, 1'b0);
    run_phase(11'd17, 1'b1, 100, 1'b1);
    run_phase(11'd5, 1'b1, 50, 1'b0);

    while (pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
